>>> rtl/bbc_pkg.sv
`timescale 1ns / 1ps
package bbc_pkg;

  localparam int ENTRIES  = 16;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam int ID_W     = 32;
  localparam int BYTES_W  = 32;
  localparam int TIME_W   = 48;
  localparam int TOTAL_W  = 36;
  localparam int ALU_W    = 48;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 64;

  localparam logic [TOTAL_W-1:0] BUDGET_RST  = TOTAL_W'(64'd268435456);
  localparam logic [TIME_W-1:0]  TIMEOUT_RST = TIME_W'(64'd30000000000);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_UNLOAD = 2'd2,
    OP_TRIM   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_MISS      = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_INS_OVER  = 3'd3,
    ST_UNLOADED  = 3'd4,
    ST_EVICTED   = 3'd5,
    ST_TRIM_DONE = 3'd6,
    ST_NOT_FOUND = 3'd7
  } status_t;

  typedef enum logic [0:0] {
    REG_BUDGET  = 1'b0,
    REG_TIMEOUT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ALU_EQ   = 2'd0,
    ALU_LT   = 2'd1,
    ALU_IDLE = 2'd2,
    ALU_OVER = 2'd3
  } alu_mode_t;

  typedef struct packed {
    alu_mode_t        mode;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic [ALU_W-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BYTES_W-1:0] bytes;
    logic [TIME_W-1:0]  stamp;
  } slot_t;

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    slot_t wdata;
    logic  vset;
    logic  vclr;
    idx_t  vidx;
  } store_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_FIND_DONE,
    S_CHECK,
    S_EVICT,
    S_EVICT_DONE,
    S_PLACE,
    S_TRIM,
    S_TRIM_DONE
  } state_t;

endpackage

>>> rtl/bbc_alu.sv
`timescale 1ns / 1ps
module bbc_alu (
  input  bbc_pkg::alu_req_t req,
  output logic              flag
);
  import bbc_pkg::*;

  logic [ALU_W-1:0] diff;
  logic [ALU_W:0]   sum;
  logic             a_ge_b;

  assign diff   = req.a - req.b;
  assign sum    = {1'b0, req.a} + {1'b0, req.b};
  assign a_ge_b = (req.a >= req.b);

  always_comb begin
    unique case (req.mode)
      ALU_EQ:   flag = (req.a == req.b);
      ALU_LT:   flag = !a_ge_b;
      // not idle when the stored stamp lies in the future
      ALU_IDLE: flag = a_ge_b && (diff > req.c);
      ALU_OVER: flag = (sum > {1'b0, req.c});
      default:  flag = 1'b0;
    endcase
  end

endmodule

>>> rtl/bbc_slot_store.sv
`timescale 1ns / 1ps
module bbc_slot_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bbc_pkg::store_cmd_t  cmd,
  input  bbc_pkg::idx_t        rd_addr,
  output bbc_pkg::slot_t       rd_data,
  output logic [bbc_pkg::ENTRIES-1:0] valid
);
  import bbc_pkg::*;

  slot_t               slot_mem_r [ENTRIES];
  slot_t               rd_data_r;
  logic [ENTRIES-1:0]  valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.vset) begin
      valid_r[cmd.vidx] <= 1'b1;
    end else if (cmd.vclr) begin
      valid_r[cmd.vidx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      slot_mem_r[cmd.waddr] <= cmd.wdata;
    end
    rd_data_r <= slot_mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;
  assign valid   = valid_r;

endmodule

>>> rtl/bbc_ctrl.sv
`timescale 1ns / 1ps
module bbc_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_operation,
  input  logic [bbc_pkg::ID_W-1:0]      in_asset_id,
  input  logic [bbc_pkg::BYTES_W-1:0]   in_entry_bytes,
  input  logic [bbc_pkg::TIME_W-1:0]    in_now_time,
  input  logic [bbc_pkg::TOTAL_W-1:0]   budget,
  input  logic [bbc_pkg::TIME_W-1:0]    timeout,
  output bbc_pkg::store_cmd_t           cmd,
  output bbc_pkg::idx_t                 rd_addr,
  input  bbc_pkg::slot_t                rd_data,
  input  logic [bbc_pkg::ENTRIES-1:0]   valid,
  output bbc_pkg::alu_req_t             alu_req,
  input  logic                          alu_flag,
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [bbc_pkg::ID_W-1:0]      out_result_id,
  output logic [bbc_pkg::BYTES_W-1:0]   out_result_bytes,
  output logic [bbc_pkg::TOTAL_W-1:0]   out_total_bytes,
  output logic                          out_last
);
  import bbc_pkg::*;

  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  logic [BYTES_W-1:0]   bytes_r, bytes_nxt;
  logic [TIME_W-1:0]    now_r, now_nxt;
  cnt_t                 iss_r, iss_nxt;
  logic                 dat_v_r, dat_v_nxt;
  idx_t                 dat_idx_r, dat_idx_nxt;
  logic                 match_v_r, match_v_nxt;
  idx_t                 match_idx_r, match_idx_nxt;
  logic [BYTES_W-1:0]   match_bytes_r, match_bytes_nxt;
  logic                 best_v_r, best_v_nxt;
  idx_t                 best_idx_r, best_idx_nxt;
  logic [TIME_W-1:0]    best_time_r, best_time_nxt;
  logic [ID_W-1:0]      best_id_r, best_id_nxt;
  logic [BYTES_W-1:0]   best_bytes_r, best_bytes_nxt;
  logic                 over_r, over_nxt;
  idx_t                 place_idx_r, place_idx_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  cnt_t                 cnt_r, cnt_nxt;
  logic                 out_v_r, out_v_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [ID_W-1:0]      out_id_r, out_id_nxt;
  logic [BYTES_W-1:0]   out_bytes_r, out_bytes_nxt;
  logic [TOTAL_W-1:0]   out_total_r, out_total_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 cur_valid;
  logic                 last_el;

  function automatic logic [TOTAL_W-1:0] sat_sub(input logic [TOTAL_W-1:0] t,
                                                 input logic [BYTES_W-1:0] b);
    logic [TOTAL_W-1:0] bx;
    bx = TOTAL_W'(b);
    return (bx > t) ? '0 : t - bx;
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] t,
                                                 input logic [BYTES_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, t} + (TOTAL_W + 1)'(b);
    return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
  endfunction

  assign rd_addr   = iss_r[IDX_W-1:0];
  assign cur_valid = dat_v_r && valid[dat_idx_r];
  assign last_el   = dat_v_r && (dat_idx_r == LAST_IDX);
  assign busy      = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      total_r  <= '0;
      cnt_r    <= '0;
      out_v_r  <= 1'b0;
      dat_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      cnt_r    <= cnt_nxt;
      out_v_r  <= out_v_nxt;
      dat_v_r  <= dat_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    id_r          <= id_nxt;
    bytes_r       <= bytes_nxt;
    now_r         <= now_nxt;
    iss_r         <= iss_nxt;
    dat_idx_r     <= dat_idx_nxt;
    match_v_r     <= match_v_nxt;
    match_idx_r   <= match_idx_nxt;
    match_bytes_r <= match_bytes_nxt;
    best_v_r      <= best_v_nxt;
    best_idx_r    <= best_idx_nxt;
    best_time_r   <= best_time_nxt;
    best_id_r     <= best_id_nxt;
    best_bytes_r  <= best_bytes_nxt;
    over_r        <= over_nxt;
    place_idx_r   <= place_idx_nxt;
    out_status_r  <= out_status_nxt;
    out_id_r      <= out_id_nxt;
    out_bytes_r   <= out_bytes_nxt;
    out_total_r   <= out_total_nxt;
    out_last_r    <= out_last_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    id_nxt          = id_r;
    bytes_nxt       = bytes_r;
    now_nxt         = now_r;
    iss_nxt         = iss_r;
    dat_v_nxt       = 1'b0;
    dat_idx_nxt     = dat_idx_r;
    match_v_nxt     = match_v_r;
    match_idx_nxt   = match_idx_r;
    match_bytes_nxt = match_bytes_r;
    best_v_nxt      = best_v_r;
    best_idx_nxt    = best_idx_r;
    best_time_nxt   = best_time_r;
    best_id_nxt     = best_id_r;
    best_bytes_nxt  = best_bytes_r;
    over_nxt        = over_r;
    place_idx_nxt   = place_idx_r;
    total_nxt       = total_r;
    cnt_nxt         = cnt_r;
    out_v_nxt       = 1'b0;
    out_status_nxt  = out_status_r;
    out_id_nxt      = out_id_r;
    out_bytes_nxt   = out_bytes_r;
    out_total_nxt   = out_total_r;
    out_last_nxt    = out_last_r;
    cmd             = '0;
    alu_req         = '{mode: ALU_EQ, a: '0, b: '0, c: '0};

    // scan states issue one slot read a cycle; data comes back in the next cycle
    if (state_r == S_FIND || state_r == S_EVICT || state_r == S_TRIM) begin
      if (iss_r < CNT_W'(ENTRIES)) begin
        iss_nxt     = iss_r + CNT_W'(1);
        dat_v_nxt   = 1'b1;
        dat_idx_nxt = iss_r[IDX_W-1:0];
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt      = op_t'(in_operation);
          id_nxt      = in_asset_id;
          bytes_nxt   = in_entry_bytes;
          now_nxt     = in_now_time;
          iss_nxt     = '0;
          match_v_nxt = 1'b0;
          state_nxt   = (op_t'(in_operation) == OP_TRIM) ? S_TRIM : S_FIND;
        end
      end

      S_FIND: begin
        alu_req = '{mode: ALU_EQ, a: ALU_W'(rd_data.id), b: ALU_W'(id_r), c: '0};
        if (cur_valid && alu_flag && !match_v_r) begin
          match_v_nxt     = 1'b1;
          match_idx_nxt   = dat_idx_r;
          match_bytes_nxt = rd_data.bytes;
        end
        if (last_el) begin
          state_nxt = S_FIND_DONE;
        end
      end

      S_FIND_DONE: begin
        out_id_nxt = id_r;
        unique case (op_r)
          OP_LOOKUP: begin
            out_v_nxt     = 1'b1;
            out_last_nxt  = 1'b1;
            out_total_nxt = total_r;
            if (match_v_r) begin
              cmd.we         = 1'b1;
              cmd.waddr      = match_idx_r;
              cmd.wdata      = '{id: id_r, bytes: match_bytes_r, stamp: now_r};
              out_status_nxt = ST_HIT;
              out_bytes_nxt  = match_bytes_r;
            end else begin
              out_status_nxt = ST_MISS;
              out_bytes_nxt  = '0;
            end
            state_nxt = S_IDLE;
          end
          OP_UNLOAD: begin
            out_v_nxt    = 1'b1;
            out_last_nxt = 1'b1;
            if (match_v_r) begin
              cmd.vclr       = 1'b1;
              cmd.vidx       = match_idx_r;
              cnt_nxt        = cnt_r - CNT_W'(1);
              total_nxt      = sat_sub(total_r, match_bytes_r);
              out_status_nxt = ST_UNLOADED;
              out_bytes_nxt  = match_bytes_r;
            end else begin
              out_status_nxt = ST_NOT_FOUND;
              out_bytes_nxt  = '0;
            end
            out_total_nxt = total_nxt;
            state_nxt     = S_IDLE;
          end
          OP_INSERT: begin
            // drop an old copy of the id without a result
            if (match_v_r) begin
              cmd.vclr  = 1'b1;
              cmd.vidx  = match_idx_r;
              cnt_nxt   = cnt_r - CNT_W'(1);
              total_nxt = sat_sub(total_r, match_bytes_r);
            end
            state_nxt = S_CHECK;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_CHECK: begin
        alu_req = '{mode: ALU_OVER, a: ALU_W'(total_r), b: ALU_W'(bytes_r),
                    c: ALU_W'(budget)};
        if ((alu_flag && cnt_r != '0) || cnt_r == CNT_W'(ENTRIES)) begin
          iss_nxt    = '0;
          best_v_nxt = 1'b0;
          state_nxt  = S_EVICT;
        end else begin
          over_nxt      = alu_flag;
          place_idx_nxt = '0;
          state_nxt     = S_PLACE;
        end
      end

      S_EVICT: begin
        alu_req = '{mode: ALU_LT, a: ALU_W'(rd_data.stamp), b: ALU_W'(best_time_r),
                    c: '0};
        // strict compare keeps the lowest slot on a tie
        if (cur_valid && (!best_v_r || alu_flag)) begin
          best_v_nxt     = 1'b1;
          best_idx_nxt   = dat_idx_r;
          best_time_nxt  = rd_data.stamp;
          best_id_nxt    = rd_data.id;
          best_bytes_nxt = rd_data.bytes;
        end
        if (last_el) begin
          state_nxt = S_EVICT_DONE;
        end
      end

      S_EVICT_DONE: begin
        if (best_v_r) begin
          cmd.vclr       = 1'b1;
          cmd.vidx       = best_idx_r;
          cnt_nxt        = cnt_r - CNT_W'(1);
          total_nxt      = sat_sub(total_r, best_bytes_r);
          out_v_nxt      = 1'b1;
          out_last_nxt   = 1'b0;
          out_status_nxt = ST_EVICTED;
          out_id_nxt     = best_id_r;
          out_bytes_nxt  = best_bytes_r;
          out_total_nxt  = total_nxt;
        end
        state_nxt = S_CHECK;
      end

      S_PLACE: begin
        if (!valid[place_idx_r] || place_idx_r == LAST_IDX) begin
          if (!valid[place_idx_r]) begin
            cmd.we    = 1'b1;
            cmd.waddr = place_idx_r;
            cmd.wdata = '{id: id_r, bytes: bytes_r, stamp: now_r};
            cmd.vset  = 1'b1;
            cmd.vidx  = place_idx_r;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end
          total_nxt      = sat_add(total_r, bytes_r);
          out_v_nxt      = 1'b1;
          out_last_nxt   = 1'b1;
          out_status_nxt = over_r ? ST_INS_OVER : ST_INSERTED;
          out_id_nxt     = id_r;
          out_bytes_nxt  = bytes_r;
          out_total_nxt  = total_nxt;
          state_nxt      = S_IDLE;
        end else begin
          place_idx_nxt = place_idx_r + IDX_W'(1);
        end
      end

      S_TRIM: begin
        alu_req = '{mode: ALU_IDLE, a: ALU_W'(now_r), b: ALU_W'(rd_data.stamp),
                    c: ALU_W'(timeout)};
        if (cur_valid && alu_flag) begin
          cmd.vclr       = 1'b1;
          cmd.vidx       = dat_idx_r;
          cnt_nxt        = cnt_r - CNT_W'(1);
          total_nxt      = sat_sub(total_r, rd_data.bytes);
          out_v_nxt      = 1'b1;
          out_last_nxt   = 1'b0;
          out_status_nxt = ST_EVICTED;
          out_id_nxt     = rd_data.id;
          out_bytes_nxt  = rd_data.bytes;
          out_total_nxt  = total_nxt;
        end
        if (last_el) begin
          state_nxt = S_TRIM_DONE;
        end
      end

      S_TRIM_DONE: begin
        out_v_nxt      = 1'b1;
        out_last_nxt   = 1'b1;
        out_status_nxt = ST_TRIM_DONE;
        out_id_nxt     = '0;
        out_bytes_nxt  = '0;
        out_total_nxt  = total_r;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid        = out_v_r;
  assign out_status       = out_status_r;
  assign out_result_id    = out_id_r;
  assign out_result_bytes = out_bytes_r;
  assign out_total_bytes  = out_total_r;
  assign out_last         = out_last_r;

endmodule

>>> rtl/byte_budget_lru_cache_top.sv
`timescale 1ns / 1ps
// Byte-budgeted LRU cache table with idle expiry.
//
// Input channel: drive in_operation, in_asset_id, in_entry_bytes and in_now_time
// with start; the item is taken at a rising edge with start high and busy low.
// busy drops in the cycle that shows the last result of the item, and the next
// item may be taken in that same cycle.
// Result channel: every result is shown for exactly one cycle with out_valid
// high; out_last marks the final result of an item. The receiver cannot stall,
// so results are simply dropped onto the ports one per cycle when ready.
// Configuration: APB-style port, budget at byte address 0, idle timeout at
// byte address 8, 64-bit data, pready tied high. Write only while busy is low.
// Scans: each slot scan reads the slot memory one entry a cycle through one
// shared compare unit. Lookup and unload run one id scan, trim one idle scan.
// Insert runs the id scan, then one eviction scan per evicted entry, then a
// search from slot 0 upward for the lowest free slot; evict results follow
// each eviction scan. A new item is taken only once the last one is done.
// Reset (rst_n low, synchronous) clears all slot valid bits, the byte total
// and the configuration registers to their defaults; no clearing pass is needed.
module byte_budget_lru_cache_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_operation,
  input  logic [bbc_pkg::ID_W-1:0]           in_asset_id,
  input  logic [bbc_pkg::BYTES_W-1:0]        in_entry_bytes,
  input  logic [bbc_pkg::TIME_W-1:0]         in_now_time,
  output logic                               out_valid,
  output logic [2:0]                         out_status,
  output logic [bbc_pkg::ID_W-1:0]           out_result_id,
  output logic [bbc_pkg::BYTES_W-1:0]        out_result_bytes,
  output logic [bbc_pkg::TOTAL_W-1:0]        out_total_bytes,
  output logic                               out_last,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bbc_pkg::APB_AW-1:0]         paddr,
  input  logic [bbc_pkg::APB_DW-1:0]         pwdata,
  output logic [bbc_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);
  import bbc_pkg::*;

  logic [TOTAL_W-1:0] budget_r, budget_nxt;
  logic [TIME_W-1:0]  timeout_r, timeout_nxt;
  reg_idx_t           reg_sel;
  logic               cfg_wr;

  store_cmd_t          cmd;
  idx_t                rd_addr;
  slot_t               rd_data;
  logic [ENTRIES-1:0]  valid;
  alu_req_t            alu_req;
  logic                alu_flag;

  // Registers sit on 8-byte boundaries; the top address bit picks one.
  assign reg_sel = reg_idx_t'(paddr[APB_AW-1]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    budget_nxt  = budget_r;
    timeout_nxt = timeout_r;
    prdata      = '0;
    unique case (reg_sel)
      REG_BUDGET: begin
        prdata = APB_DW'(budget_r);
        if (cfg_wr) begin
          budget_nxt = pwdata[TOTAL_W-1:0];
        end
      end
      REG_TIMEOUT: begin
        prdata = APB_DW'(timeout_r);
        if (cfg_wr) begin
          timeout_nxt = pwdata[TIME_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r  <= BUDGET_RST;
      timeout_r <= TIMEOUT_RST;
    end else begin
      budget_r  <= budget_nxt;
      timeout_r <= timeout_nxt;
    end
  end

  // Slot table: valid flops plus one read port, one write port memory.
  bbc_slot_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .valid   (valid)
  );

  // Shared compare unit: id match, LRU order, idle test and budget test.
  bbc_alu u_alu (
    .req  (alu_req),
    .flag (alu_flag)
  );

  // Sequencer: scans, evictions, placement and result generation.
  bbc_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_asset_id      (in_asset_id),
    .in_entry_bytes   (in_entry_bytes),
    .in_now_time      (in_now_time),
    .budget           (budget_r),
    .timeout          (timeout_r),
    .cmd              (cmd),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .valid            (valid),
    .alu_req          (alu_req),
    .alu_flag         (alu_flag),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_id    (out_result_id),
    .out_result_bytes (out_result_bytes),
    .out_total_bytes  (out_total_bytes),
    .out_last         (out_last)
  );

endmodule

>>> rtl/bbc_checker.sv
`timescale 1ns / 1ps
module bbc_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_last
);

  // an accepted item holds the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // the last result coincides with the block going idle, earlier ones do not
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == !busy))
    else $error("result last flag disagrees with busy");

  // busy only drops together with the final result of an item
  a_fall_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid && out_last))
    else $error("busy dropped without a final result");

  // no result directly follows a final result
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result right after a final result");

endmodule

bind byte_budget_lru_cache_top bbc_checker u_bbc_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import bbc_pkg::*;

  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES = 64;
  localparam int POOL_SIZE     = 20;
  localparam int RANDOM_ITEMS  = 470;
  localparam int PHASE_ITEMS   = RANDOM_ITEMS / 5;
  localparam logic [TOTAL_W-1:0] BUDGET_MAX = '1;
  localparam logic [TIME_W-1:0]  TIME_MAX   = '1;

  typedef struct {
    status_t            status;
    logic [ID_W-1:0]    id;
    logic [BYTES_W-1:0] nbytes;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } cache_result_t;

  // Mirror of the cache table: predicts the results of every accepted item
  // and holds them until the block presents them.
  class lru_cache_mirror;
    bit                 used   [ENTRIES];
    bit [ID_W-1:0]      ids    [ENTRIES];
    bit [BYTES_W-1:0]   sizes  [ENTRIES];
    bit [TIME_W-1:0]    stamps [ENTRIES];
    bit [TOTAL_W-1:0]   held;
    bit [TOTAL_W-1:0]   budget;
    bit [TIME_W-1:0]    timeout;
    cache_result_t      awaited[$];
    cache_result_t      batch[$];
    int unsigned        errors;

    function new();
      foreach (used[i]) used[i] = 1'b0;
      held    = '0;
      budget  = BUDGET_RST;
      timeout = TIMEOUT_RST;
      errors  = 0;
    endfunction

    function void post(status_t st, bit [ID_W-1:0] id, bit [BYTES_W-1:0] nbytes);
      cache_result_t r;
      r.status = st;
      r.id     = id;
      r.nbytes = nbytes;
      r.total  = held;
      r.last   = 1'b0;
      batch    = {batch, r};
    endfunction

    // The total stops at zero going down and saturates going up.
    function void shrink(bit [BYTES_W-1:0] nbytes);
      held = (TOTAL_W'(nbytes) > held) ? '0 : held - TOTAL_W'(nbytes);
    endfunction

    function void grow(bit [BYTES_W-1:0] nbytes);
      bit [TOTAL_W:0] sum;
      sum  = {1'b0, held} + (TOTAL_W+1)'(nbytes);
      held = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    endfunction

    function bit too_big(bit [BYTES_W-1:0] nbytes);
      return ({1'b0, held} + (TOTAL_W+1)'(nbytes)) > {1'b0, budget};
    endfunction

    function int slot_of(bit [ID_W-1:0] id);
      int i;
      for (i = 0; i < ENTRIES; i++)
        if (used[i] && ids[i] == id) return i;
      return -1;
    endfunction

    function int occupancy();
      int i;
      int n;
      n = 0;
      for (i = 0; i < ENTRIES; i++)
        if (used[i]) n++;
      return n;
    endfunction

    function void drop_slot(int i);
      used[i] = 1'b0;
      shrink(sizes[i]);
      post(ST_EVICTED, ids[i], sizes[i]);
    endfunction

    // Oldest stamp goes first; on a tie the lowest slot goes.
    function void evict_oldest();
      int i;
      int pick;
      pick = -1;
      for (i = 0; i < ENTRIES; i++)
        if (used[i] && (pick < 0 || stamps[i] < stamps[pick])) pick = i;
      if (pick >= 0) drop_slot(pick);
    endfunction

    function void note_item(op_t op, bit [ID_W-1:0] id, bit [BYTES_W-1:0] nbytes,
                            bit [TIME_W-1:0] now);
      int            i;
      int            s;
      int            spot;
      status_t       verdict;
      batch.delete();
      s = slot_of(id);
      case (op)
        OP_LOOKUP: begin
          if (s >= 0) begin
            stamps[s] = now;
            post(ST_HIT, id, sizes[s]);
          end else begin
            post(ST_MISS, id, '0);
          end
        end
        OP_INSERT: begin
          // A present id leaves silently before the new copy goes in.
          if (s >= 0) begin
            used[s] = 1'b0;
            shrink(sizes[s]);
          end
          while (too_big(nbytes) && occupancy() > 0) evict_oldest();
          if (occupancy() >= ENTRIES) evict_oldest();
          verdict = too_big(nbytes) ? ST_INS_OVER : ST_INSERTED;
          spot = -1;
          for (i = ENTRIES - 1; i >= 0; i--)
            if (!used[i]) spot = i;
          if (spot >= 0) begin
            used[spot]   = 1'b1;
            ids[spot]    = id;
            sizes[spot]  = nbytes;
            stamps[spot] = now;
          end
          grow(nbytes);
          post(verdict, id, nbytes);
        end
        OP_UNLOAD: begin
          if (s >= 0) begin
            used[s] = 1'b0;
            shrink(sizes[s]);
            post(ST_UNLOADED, id, sizes[s]);
          end else begin
            post(ST_NOT_FOUND, id, '0);
          end
        end
        OP_TRIM: begin
          // A stamp later than now is not idle.
          for (i = 0; i < ENTRIES; i++)
            if (used[i] && now >= stamps[i] && now - stamps[i] > timeout) drop_slot(i);
          post(ST_TRIM_DONE, '0, '0);
        end
      endcase
      batch[batch.size() - 1].last = 1'b1;
      awaited = {awaited, batch};
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void check_result(logic [2:0] st, logic [ID_W-1:0] id,
                               logic [BYTES_W-1:0] nbytes, logic [TOTAL_W-1:0] total,
                               logic last);
      cache_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: status %0d id %h bytes %h",
                 $time, st, id, nbytes);
        return;
      end
      want = awaited.pop_front();
      compare("status", want.status, st);
      compare("result_id", want.id, id);
      compare("result_bytes", want.nbytes, nbytes);
      compare("total_bytes", want.total, total);
      compare("last", want.last, last);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_operation;
  logic [ID_W-1:0]      in_asset_id;
  logic [BYTES_W-1:0]   in_entry_bytes;
  logic [TIME_W-1:0]    in_now_time;
  logic                 out_valid;
  logic [2:0]           out_status;
  logic [ID_W-1:0]      out_result_id;
  logic [BYTES_W-1:0]   out_result_bytes;
  logic [TOTAL_W-1:0]   out_total_bytes;
  logic                 out_last;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  lru_cache_mirror      mirror;
  logic [ID_W-1:0]      id_pool [POOL_SIZE];
  logic [TIME_W-1:0]    stamp_base;
  int unsigned          idle_pct;
  int unsigned          random_sent = 0;
  int unsigned          cycles = 0;

  byte_budget_lru_cache_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_asset_id      (in_asset_id),
    .in_entry_bytes   (in_entry_bytes),
    .in_now_time      (in_now_time),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_id    (out_result_id),
    .out_result_bytes (out_result_bytes),
    .out_total_bytes  (out_total_bytes),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every result is shown for one cycle only; take it at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      mirror.check_result(out_status, out_result_id, out_result_bytes, out_total_bytes,
                          out_last);
  end

  // Hard stop in case the block hangs or stops presenting results.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic logic [31:0] pick_upto(logic [31:0] cap);
    return (cap == '1) ? $urandom : $urandom_range(cap);
  endfunction

  // Offer one item at the falling edge, with a random gap ahead of it, and
  // hold it until the block takes it.
  task automatic send_item(op_t op, logic [ID_W-1:0] id, logic [BYTES_W-1:0] nbytes,
                           logic [TIME_W-1:0] now);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start          <= 1'b1;
    in_operation   <= op;
    in_asset_id    <= id;
    in_entry_bytes <= nbytes;
    in_now_time    <= now;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    mirror.note_item(op, id, nbytes, now);
  endtask

  // Drop start and wait until every predicted result has come back.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (mirror.awaited.size() != 0 || busy !== 1'b0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write a register, then read it back in the transfer right after.
  task automatic write_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] stored;
    stored = (idx == REG_BUDGET) ? APB_DW'(value[TOTAL_W-1:0]) : APB_DW'(value[TIME_W-1:0]);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 3'b000});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    mirror.compare("register readback", stored, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_BUDGET) mirror.budget = stored[TOTAL_W-1:0];
    else mirror.timeout = stored[TIME_W-1:0];
  endtask

  // Random cache traffic over a fresh pool of ids: mostly pool ids so hits,
  // re-inserts and unloads of present entries are common, some stray ids.
  task automatic run_phase(int count, logic [31:0] cap, logic [31:0] step,
                           logic [TIME_W-1:0] origin);
    int unsigned        roll;
    op_t                op;
    logic [ID_W-1:0]    id;
    logic [BYTES_W-1:0] nbytes;
    logic [TIME_W-1:0]  now;
    stamp_base = origin;
    foreach (id_pool[i]) id_pool[i] = $urandom;
    repeat (count) begin
      // Sender idles often first, heavily next, then not at all.
      if (random_sent < RANDOM_ITEMS / 3) idle_pct = 19;
      else if (random_sent < 2 * RANDOM_ITEMS / 3) idle_pct = 65;
      else idle_pct = 0;
      roll = $urandom_range(99);
      if (roll < 40) op = OP_INSERT;
      else if (roll < 65) op = OP_LOOKUP;
      else if (roll < 80) op = OP_UNLOAD;
      else op = OP_TRIM;
      id = ($urandom_range(9) == 0) ? $urandom : id_pool[$urandom_range(POOL_SIZE - 1)];
      nbytes = ($urandom_range(19) == 0) ? '0 : pick_upto(cap);
      stamp_base = stamp_base + pick_upto(step);
      roll = $urandom_range(99);
      if (roll < 4) now = TIME_W'({$urandom, $urandom});
      else if (roll < 10) now = stamp_base - pick_upto(step);
      else now = stamp_base;
      send_item(op, id, nbytes, now);
      random_sent++;
    end
  endtask

  initial begin
    int                 i;
    logic [TOTAL_W-1:0] rand_budget;
    logic [TIME_W-1:0]  rand_timeout;
    mirror         = new();
    rst_n          = 1'b0;
    start          = 1'b0;
    in_operation   = '0;
    in_asset_id    = '0;
    in_entry_bytes = '0;
    in_now_time    = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    idle_pct       = 19;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset registers.
    send_item(OP_LOOKUP, 32'd5, 32'd0, 48'd100);
    send_item(OP_UNLOAD, 32'd5, 32'd0, 48'd100);
    send_item(OP_INSERT, 32'd0, 32'd0, 48'd0);
    // Larger than the budget: empty the table, then store over budget.
    send_item(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'd1);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'd0, 48'd2);
    send_item(OP_INSERT, 32'd1, 32'd100, 48'd2);
    // Re-insert a present id with a new size.
    send_item(OP_INSERT, 32'd1, 32'd200, 48'd5);
    // Fill the table with equal stamps; the next insert evicts on a tie.
    for (i = 10; i <= 24; i++) send_item(OP_INSERT, ID_W'(i), 32'd1, 48'd5);
    send_item(OP_INSERT, 32'd25, 32'd1, 48'd6);
    send_item(OP_UNLOAD, 32'd12, 32'd0, 48'd6);
    // Stamp in the far future must survive a trim.
    send_item(OP_INSERT, 32'd7, 32'd7, TIME_MAX);
    send_item(OP_TRIM, 32'd0, 32'd0, 48'd40_000_000_000);
    send_item(OP_LOOKUP, 32'd7, 32'd0, 48'd50);
    settle();

    run_phase(PHASE_ITEMS, 32'h0200_0000, 32'd2_000_000_000, 48'd0);
    settle();

    write_reg(REG_BUDGET, '0);
    write_reg(REG_TIMEOUT, '0);
    run_phase(PHASE_ITEMS, 32'd3, 32'd3, 48'd1000);
    settle();

    write_reg(REG_BUDGET, APB_DW'(BUDGET_MAX));
    write_reg(REG_TIMEOUT, APB_DW'(TIME_MAX));
    run_phase(PHASE_ITEMS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_0000_0000);
    settle();

    write_reg(REG_BUDGET, 64'd5000);
    write_reg(REG_TIMEOUT, 64'd40);
    run_phase(PHASE_ITEMS, 32'd2000, 32'd15, 48'd0);
    settle();

    rand_budget  = {4'($urandom), 32'($urandom)};
    rand_timeout = TIME_W'($urandom_range(100000, 1));
    write_reg(REG_BUDGET, APB_DW'(rand_budget));
    write_reg(REG_TIMEOUT, APB_DW'(rand_timeout));
    run_phase(RANDOM_ITEMS - 4 * PHASE_ITEMS, 32'hFFFF_FFFF, 32'(rand_timeout / 4 + 1),
              TIME_W'({$urandom, $urandom}));
    settle();

    if (mirror.errors == 0 && mirror.awaited.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bbc_pkg.sv
rtl/bbc_alu.sv
rtl/bbc_slot_store.sv
rtl/bbc_ctrl.sv
rtl/byte_budget_lru_cache_top.sv
rtl/bbc_checker.sv
tb/sv/testbench.sv
